[hdl/pge_pkg.sv]
// ----------------------------------------------------------------------------
// pge_pkg
// Shared types, constants and the pixel expansion function of the glyph
// coverage expander.
// ----------------------------------------------------------------------------
package pge_pkg;

   localparam logic [7:0] MAX_SIDE = 8'd255;

   localparam logic [3:0] BPP_1 = 4'd1;
   localparam logic [3:0] BPP_2 = 4'd2;
   localparam logic [3:0] BPP_4 = 4'd4;
   localparam logic [3:0] BPP_8 = 4'd8;

   localparam logic [3:0] BPP_RESET = BPP_4;

   localparam logic REG_BPP    = 1'b0;
   localparam logic REG_STRIDE = 1'b1;

   localparam logic [7:0] SCALE2 [4] = '{8'd0, 8'd85, 8'd170, 8'd255};

   typedef struct packed {
      logic [3:0] bpp;
      logic [7:0] stride;
   } cfg_type;

   // sh holds the pixel bits aligned at the top of the byte
   function automatic logic [7:0] expand_px(logic [7:0] sh, logic [3:0] bpp);
      logic [7:0] px;
      px = sh;
      case (bpp)
         BPP_1: px = sh[7] ? 8'hff : 8'h00;
         BPP_2: px = SCALE2[sh[7:6]];
         BPP_4: px = {sh[7:4], sh[7:4]};
         default: px = sh;
      endcase
      return px;
   endfunction

   function automatic logic [7:0] clamp_side(logic [7:0] v);
      return (v > MAX_SIDE) ? MAX_SIDE : v;
   endfunction

endpackage

[hdl/pge_csr.sv]
// ----------------------------------------------------------------------------
// pge_csr
// Configuration registers: pixel depth and source row stride.
// ----------------------------------------------------------------------------
module pge_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata,
   output pge_pkg::cfg_type  cfg
);

   logic [3:0] bpp_ff, bpp_in;
   logic [7:0] pitch_ff, pitch_in;
   logic       wr;

   assign csr_ready = 1'b1;
   assign wr = csr_valid && csr_ready;

   always_comb begin
      bpp_in   = bpp_ff;
      pitch_in = pitch_ff;
      if (wr) begin
         case (csr_index)
            pge_pkg::REG_BPP:    bpp_in   = csr_wdata[3:0];
            pge_pkg::REG_STRIDE: pitch_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= pge_pkg::BPP_RESET;
         pitch_ff <= 8'd0;
      end else begin
         bpp_ff   <= bpp_in;
         pitch_ff <= pitch_in;
      end
   end

   assign cfg.bpp    = bpp_ff;
   assign cfg.stride = pitch_ff;

endmodule

[hdl/pge_expand.sv]
// ----------------------------------------------------------------------------
// pge_expand
// Byte register, per-pixel raster walker and result register. One pixel of
// the held byte is expanded and registered each cycle unless rsp_stall holds the result register.
// ----------------------------------------------------------------------------
module pge_expand (
   input  logic              clock,
   input  logic              reset,
   input  pge_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_raw_byte,
   input  logic              req_first_of_glyph,
   input  logic [7:0]        req_glyph_width,
   input  logic [7:0]        req_glyph_height,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_alpha,
   output logic              rsp_row_end,
   output logic              rsp_glyph_end,
   output logic              rsp_last_from_byte
);

   // byte register
   logic       byte_vld_ff, byte_vld_in;
   logic [7:0] byte_ff, byte_in;
   logic       first_ff, first_in;
   logic [7:0] bw_ff, bw_in;
   logic [7:0] bh_ff, bh_in;

   // glyph walker state
   logic       active_ff, active_in;
   logic [7:0] width_ff, width_in;
   logic [7:0] height_ff, height_in;
   logic [7:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;
   logic [7:0] rbt_ff, rbt_in;
   logic [2:0] off_ff, off_in;

   // result register
   logic       out_vld_ff, out_vld_in;
   logic [7:0] alpha_ff, alpha_in;
   logic       rend_ff, rend_in;
   logic       gend_ff, gend_in;
   logic       lfb_ff, lfb_in;

   logic       out_free, go, done, accept;
   logic       act_e, bpp_ok, stride_nz, pad, emit;
   logic [7:0] wid_e, hgt_e, col_e, row_e, rbt_e;
   logic [2:0] off_e;
   logic [8:0] col_inc, row_inc;
   logic       rend, gend, done_px;
   logic [3:0] off_sum;
   logic [7:0] col_n, rbt_s, rbt_p, sh;

   assign out_free = !out_vld_ff || !rsp_stall;
   assign go       = byte_vld_ff && out_free;

   always_comb begin
      if (first_ff) begin
         wid_e = pge_pkg::clamp_side(bw_ff);
         hgt_e = pge_pkg::clamp_side(bh_ff);
         act_e = (wid_e != 8'd0) && (hgt_e != 8'd0);
         col_e = 8'd0;
         row_e = 8'd0;
         rbt_e = 8'd0;
         off_e = 3'd0;
      end else begin
         wid_e = width_ff;
         hgt_e = height_ff;
         act_e = active_ff;
         col_e = col_ff;
         row_e = row_ff;
         rbt_e = rbt_ff;
         off_e = off_ff;
      end
   end

   assign bpp_ok = (cfg.bpp == pge_pkg::BPP_1) || (cfg.bpp == pge_pkg::BPP_2) ||
                   (cfg.bpp == pge_pkg::BPP_4) || (cfg.bpp == pge_pkg::BPP_8);
   assign stride_nz = cfg.stride != 8'd0;
   assign pad  = stride_nz && (col_e == 8'd0) && (rbt_e != 8'd0) && (off_e == 3'd0);
   assign emit = act_e && bpp_ok && !pad;

   assign col_inc = {1'b0, col_e} + 9'd1;
   assign row_inc = {1'b0, row_e} + 9'd1;
   assign rend    = col_inc >= {1'b0, wid_e};
   assign gend    = rend && (row_inc >= {1'b0, hgt_e});
   assign col_n   = rend ? 8'd0 : col_inc[7:0];
   assign off_sum = {1'b0, off_e} + cfg.bpp;
   assign done_px = off_sum[3] || gend || (rend && stride_nz);
   assign done    = !emit || done_px;

   assign rbt_s = (rbt_e == 8'hff) ? 8'hff : rbt_e + 8'd1;
   assign rbt_p = rbt_e + 8'd1;
   assign sh    = byte_ff << off_e;

   assign accept    = req_valid && !req_stall;
   assign req_stall = byte_vld_ff && !(go && done);

   always_comb begin
      byte_vld_in = byte_vld_ff;
      byte_in     = byte_ff;
      first_in    = first_ff;
      bw_in       = bw_ff;
      bh_in       = bh_ff;
      active_in   = active_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      rbt_in      = rbt_ff;
      off_in      = off_ff;

      if (go) begin
         // commit the glyph size on the first step of a new glyph
         width_in  = wid_e;
         height_in = hgt_e;
         active_in = act_e;
         col_in    = col_e;
         row_in    = row_e;
         rbt_in    = rbt_e;
         off_in    = 3'd0;
         first_in  = 1'b0;
         if (act_e && bpp_ok) begin
            if (pad) begin
               rbt_in = (rbt_p >= cfg.stride) ? 8'd0 : rbt_p;
            end else begin
               col_in    = col_n;
               row_in    = rend ? row_inc[7:0] : row_e;
               active_in = !gend;
               off_in    = done_px ? 3'd0 : off_sum[2:0];
               if (done_px && stride_nz) begin
                  rbt_in = ((col_n == 8'd0) && (rbt_s >= cfg.stride)) ? 8'd0 : rbt_s;
               end
            end
         end
         if (done) begin
            byte_vld_in = 1'b0;
         end
      end

      if (accept) begin
         byte_vld_in = 1'b1;
         byte_in     = req_raw_byte;
         first_in    = req_first_of_glyph;
         bw_in       = req_glyph_width;
         bh_in       = req_glyph_height;
      end
   end

   always_comb begin
      out_vld_in = (go && emit) || (out_vld_ff && rsp_stall);
      alpha_in   = alpha_ff;
      rend_in    = rend_ff;
      gend_in    = gend_ff;
      lfb_in     = lfb_ff;
      if (go && emit) begin
         alpha_in = pge_pkg::expand_px(sh, cfg.bpp);
         rend_in  = rend;
         gend_in  = gend;
         lfb_in   = done_px;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
         first_ff    <= 1'b0;
         active_ff   <= 1'b0;
         width_ff    <= 8'd0;
         height_ff   <= 8'd0;
         col_ff      <= 8'd0;
         row_ff      <= 8'd0;
         rbt_ff      <= 8'd0;
         off_ff      <= 3'd0;
         out_vld_ff  <= 1'b0;
      end else begin
         byte_vld_ff <= byte_vld_in;
         first_ff    <= first_in;
         active_ff   <= active_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         rbt_ff      <= rbt_in;
         off_ff      <= off_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      bw_ff    <= bw_in;
      bh_ff    <= bh_in;
      alpha_ff <= alpha_in;
      rend_ff  <= rend_in;
      gend_ff  <= gend_in;
      lfb_ff   <= lfb_in;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_alpha          = alpha_ff;
   assign rsp_row_end        = rend_ff;
   assign rsp_glyph_end      = gend_ff;
   assign rsp_last_from_byte = lfb_ff;

   a_mid_byte_held: assert property (@(posedge clock) disable iff (reset)
      (off_ff != 3'd0) |-> byte_vld_ff)
      else $error("bit offset nonzero without a held byte");

   a_glyph_end_row_end: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && gend_ff) |-> (rend_ff && lfb_ff))
      else $error("glyph end without row end or byte end");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (col_ff < width_ff) && (row_ff < height_ff))
      else $error("walker position outside glyph box");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !byte_vld_ff |-> !req_stall)
      else $error("input stalled with empty byte register");

   a_glyph_end_idle: assert property (@(posedge clock) disable iff (reset)
      (go && emit && gend) |=> !active_ff)
      else $error("walker still active after glyph end");

endmodule

[hdl/packed_alpha_glyph_expander.sv]
// ----------------------------------------------------------------------------
// packed_alpha_glyph_expander
// Expands packed 1/2/4/8 bpp glyph coverage bytes into 8-bit alpha pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one bitmap byte per item, MSB-first pixels; the first byte
//   of a glyph has req_first_of_glyph set and carries the glyph box size.
//   rsp_* carries one pixel per item in raster order, flagged with row end,
//   glyph end and last pixel of its source byte.
//   csr_* writes bits_per_pixel (index 0) and row_stride_bytes (index 1);
//   csr_ready is always high. Write only while no byte is in flight.
// Data flow:
//   The first pixel of a byte reaches rsp_* through the byte register and
//   then the result register. The pixel walker emits one pixel per cycle
//   while rsp_stall is low, up to 8 per byte at 1 bpp and 1 at 8 bpp; bytes
//   that give no pixels are still consumed. The next byte is taken in the
//   cycle the last pixel of the current one is registered.
// Reset:
//   Clears the walker, drops any held byte and pixel, and restores 4 bpp with
//   continuous row packing.
// Stall:
//   rsp_stall holds the result register; the walker and then req_stall back
//   up behind it without losing or repeating pixels.
// ----------------------------------------------------------------------------
module packed_alpha_glyph_expander (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_raw_byte,
   input  logic       req_first_of_glyph,
   input  logic [7:0] req_glyph_width,
   input  logic [7:0] req_glyph_height,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_alpha,
   output logic       rsp_row_end,
   output logic       rsp_glyph_end,
   output logic       rsp_last_from_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   pge_pkg::cfg_type cfg;

   pge_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pge_expand u_expand (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_byte       (req_raw_byte),
      .req_first_of_glyph (req_first_of_glyph),
      .req_glyph_width    (req_glyph_width),
      .req_glyph_height   (req_glyph_height),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_alpha          (rsp_alpha),
      .rsp_row_end        (rsp_row_end),
      .rsp_glyph_end      (rsp_glyph_end),
      .rsp_last_from_byte (rsp_last_from_byte)
   );

endmodule
